// File: hdl/sni_pkg.sv
`timescale 1ns / 1ps
// sni_pkg: widths, codes, constants and shared types for the sampled integrator.
// No dependencies; used by every module under hdl.
package sni_pkg;

    localparam int X_W      = 32;
    localparam int Y_W      = 32;
    localparam int IN_W     = X_W + Y_W;
    localparam int AREA_W   = 48;
    localparam int ST_W     = 2;
    localparam int MODE_W   = 2;
    localparam int CNT_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = CNT_W;

    localparam int DEF_MAX_SAMPLES = 1024;

    // shared adder and long-multiply / long-divide widths
    localparam int ALU_W    = 50;
    localparam int A_W      = AREA_W;           // |weighted sum|
    localparam int B_W      = X_W + 2;          // |dx| * 3
    localparam int DL_W     = CNT_W + 3;        // den * last
    localparam int FRAC_W   = 16;
    localparam int D_W      = DL_W + FRAC_W;    // divisor
    localparam int Q_W      = AREA_W + 1;
    localparam int MUL_STEPS = B_W;
    localparam int DIV_STEPS = A_W + B_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_TRAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_S13  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_S38  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_COUNT = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

    localparam logic [MODE_W-1:0] RST_MODE  = MODE_TRAP;
    localparam logic [CNT_W-1:0]  RST_COUNT = 11'd3;

    localparam logic [AREA_W-1:0] ACC_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic [AREA_W-1:0] ACC_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0] rule_mode;
        logic [CNT_W-1:0]  sample_count;
    } cfg_t;

    typedef struct packed {
        logic [ALU_W-1:0] op_a;
        logic [ALU_W-1:0] op_b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [ST_W-1:0]   status;
    } res_t;

    function automatic logic [ALU_W-1:0] sext_x(input logic [X_W-1:0] v);
        return {{(ALU_W-X_W){v[X_W-1]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] sext_acc(input logic [AREA_W-1:0] v);
        return {{(ALU_W-AREA_W){v[AREA_W-1]}}, v};
    endfunction

endpackage

// File: hdl/sampled_numerical_integrator.sv
`timescale 1ns / 1ps
// sampled_numerical_integrator: top level; config registers, output register, sequencer.
// Depends on sni_pkg, sni_seq, sni_alu.
//
//   group    dir  content
//   s_axis   in   tdata = x_value[31:0], y_value[63:32]
//   m_axis   out  tdata = area[47:0]; tuser = status[1:0]
//   cfg      in   cfg_we / cfg_index / cfg_data, index 0 rule_mode, 1 sample_count
//
// A sample that is not the last of a run passes through a request and two adds.
// The last sample also runs 34 multiply and 82 divide steps,
// all on the one shared adder. A count below two answers with a count error.
// s_axis_tready is high only while the sequencer is idle; a result waits in the
// output register and the next request is taken meanwhile. No clearing pass
// after reset.
module sampled_numerical_integrator #(
    parameter int MAX_SAMPLES = sni_pkg::DEF_MAX_SAMPLES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sni_pkg::IN_W-1:0]         s_axis_tdata,   // x_value, y_value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sni_pkg::AREA_W-1:0]       m_axis_tdata,   // area
    output logic [sni_pkg::ST_W-1:0]         m_axis_tuser,   // status
    input  logic                             cfg_we,
    input  logic [sni_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sni_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sni_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic              slot_free;
    logic              res_valid;
    res_t              res;

    assign slot_free = ~out_valid_reg | m_axis_tready;

    sni_seq #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata[X_W-1:0]),
        .in_y      (s_axis_tdata[IN_W-1:X_W]),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  cfg_next.rule_mode    = cfg_data[MODE_W-1:0];
                CFG_COUNT: cfg_next.sample_count = cfg_data[CNT_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rule_mode    <= RST_MODE;
            cfg_reg.sample_count <= RST_COUNT;
            out_valid_reg        <= 1'b0;
            out_reg              <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.area;
    assign m_axis_tuser  = out_reg.status;

endmodule

// File: hdl/sni_alu.sv
`timescale 1ns / 1ps
// sni_alu: the single shared add/subtract unit of the integrator.
// Depends on sni_pkg.
module sni_alu (
    input  sni_pkg::alu_req_t          req,
    output logic [sni_pkg::ALU_W-1:0]  res
);
    import sni_pkg::*;

    assign res = req.op_a + (req.sub ? ~req.op_b : req.op_b) + ALU_W'(req.sub);

endmodule

// File: hdl/sni_seq.sv
`timescale 1ns / 1ps
// sni_seq: sequencer and datapath registers; accumulates weighted ordinates,
// runs the final multiply, divide and round on sni_alu, then saturates. Depends on sni_pkg.
module sni_seq #(
    parameter int MAX_SAMPLES = sni_pkg::DEF_MAX_SAMPLES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sni_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sni_pkg::X_W-1:0]   in_x,
    input  logic [sni_pkg::Y_W-1:0]   in_y,
    input  logic                      slot_free,
    output logic                      res_valid,
    output sni_pkg::res_t             res
);
    import sni_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC1, S_ACC2, S_ERR, S_DIFF, S_ABSA, S_ABSB,
        S_TRIPLE, S_MUL, S_DIV, S_RND, S_INC, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [Y_W-1:0]     y_reg, y_next;
    logic [X_W-1:0]     first_reg, first_next;
    logic [AREA_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]   index_reg, index_next;
    logic [1:0]         phase_reg, phase_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [CNT_W-1:0]   last_reg, last_next;
    logic [ALU_W-1:0]   tmp_reg, tmp_next;
    logic [A_W-1:0]     hi_reg, hi_next;
    logic [B_W-1:0]     lo_reg, lo_next;
    logic [D_W-1:0]     rem_reg, rem_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic               big_reg, big_next;
    logic               neg_reg, neg_next;
    logic               rnd_reg, rnd_next;
    logic [DL_W-1:0]    dl_reg, dl_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    alu_req_t           alu_req;
    logic [ALU_W-1:0]   alu_res;

    logic [CNT_W-1:0]   cnt_eff;
    logic [2:0]         weight;
    logic [ALU_W-1:0]   y_ext;
    logic [ALU_W-1:0]   y_dbl;
    logic [D_W-1:0]     divisor;
    logic [D_W:0]       rem_sh;
    logic               ge;
    logic               sat;
    logic [ALU_W-1:0]   lim;

    sni_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign cnt_eff = (int'(cfg.sample_count) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES)
                                                            : cfg.sample_count;
    assign y_ext   = sext_x(y_reg);
    assign y_dbl   = {y_ext[ALU_W-2:0], 1'b0};
    assign divisor = {dl_reg, {FRAC_W{1'b0}}};
    assign rem_sh  = {rem_reg, hi_reg[A_W-1]};
    assign ge      = ~alu_res[ALU_W-1];
    assign in_ready = (state_reg == S_IDLE);

    // ordinate weight for the sample in hand
    always_comb
    begin
        if (index_reg == '0 || index_reg >= last_reg)
        begin
            weight = 3'd1;
        end
        else
        begin
            case (mode_reg)
                MODE_S13: weight = index_reg[0] ? 3'd4 : 3'd2;
                MODE_S38: weight = (phase_reg == 2'd0) ? 3'd2 : 3'd3;
                default:  weight = 3'd2;
            endcase
        end
    end

    assign lim = neg_reg ? {{(ALU_W-AREA_W){1'b0}}, ACC_MIN}
                         : {{(ALU_W-AREA_W){1'b0}}, ACC_MAX};
    assign sat = big_reg | (tmp_reg > lim);

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        first_next = first_reg;
        sum_next   = sum_reg;
        index_next = index_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        last_next  = last_reg;
        tmp_next   = tmp_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        big_next   = big_reg;
        neg_next   = neg_reg;
        rnd_next   = rnd_reg;
        dl_next    = dl_reg;
        step_next  = step_reg;
        alu_req    = '0;
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cnt_eff < CNT_W'(2))
                    begin
                        index_next = '0;
                        phase_next = '0;
                        first_next = '0;
                        sum_next   = '0;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        last_next = cnt_eff - CNT_W'(1);
                        mode_next = cfg.rule_mode;
                        x_next    = in_x;
                        y_next    = in_y;
                        if (index_reg == '0)
                        begin
                            first_next = in_x;
                        end
                        state_next = S_ACC1;
                    end
                end
            end

            // weight w applied as two adds: 1=y+0, 2=y+y, 3=y+2y, 4=2y+2y
            S_ACC1:
            begin
                alu_req.op_a = sext_acc(sum_reg);
                alu_req.op_b = (weight == 3'd4) ? y_dbl : y_ext;
                tmp_next     = alu_res;
                state_next   = S_ACC2;
            end

            S_ACC2:
            begin
                alu_req.op_a = tmp_reg;
                case (weight)
                    3'd1:    alu_req.op_b = '0;
                    3'd2:    alu_req.op_b = y_ext;
                    default: alu_req.op_b = y_dbl;
                endcase
                if ((&alu_res[ALU_W-1:AREA_W-1]) || !(|alu_res[ALU_W-1:AREA_W-1]))
                begin
                    sum_next = alu_res[AREA_W-1:0];
                end
                else
                begin
                    sum_next = alu_res[ALU_W-1] ? ACC_MIN : ACC_MAX;
                end
                if (index_reg < last_reg)
                begin
                    index_next = index_reg + CNT_W'(1);
                    phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    res.area   = '0;
                    res.status = ST_COUNT;
                    state_next = S_IDLE;
                end
            end

            S_DIFF:
            begin
                alu_req.op_a = sext_x(x_reg);
                alu_req.op_b = sext_x(first_reg);
                alu_req.sub  = 1'b1;
                tmp_next     = alu_res;
                state_next   = S_ABSA;
            end

            S_ABSA:
            begin
                alu_req.op_b = sext_acc(sum_reg);
                alu_req.sub  = sum_reg[AREA_W-1];
                sum_next     = alu_res[AREA_W-1:0];
                neg_next     = sum_reg[AREA_W-1];
                state_next   = S_ABSB;
            end

            S_ABSB:
            begin
                alu_req.op_b = tmp_reg;
                alu_req.sub  = tmp_reg[ALU_W-1];
                tmp_next     = alu_res;
                neg_next     = neg_reg ^ tmp_reg[ALU_W-1];
                state_next   = S_TRIPLE;
            end

            // 3/8 rule: |dx| * 3; 1/3 rule: last * 3 for the divisor; trapezoid: last * 2
            S_TRIPLE:
            begin
                if (mode_reg == MODE_S38)
                begin
                    alu_req.op_a = tmp_reg;
                    alu_req.op_b = {tmp_reg[ALU_W-2:0], 1'b0};
                    tmp_next     = alu_res;
                    dl_next      = {last_reg, 3'b000};
                    lo_next      = alu_res[B_W-1:0];
                end
                else
                begin
                    alu_req.op_a = ALU_W'(last_reg);
                    alu_req.op_b = ALU_W'({last_reg, 1'b0});
                    lo_next      = tmp_reg[B_W-1:0];
                    if (mode_reg == MODE_S13)
                    begin
                        dl_next = alu_res[DL_W-1:0];
                    end
                    else
                    begin
                        dl_next = DL_W'({last_reg, 1'b0});
                    end
                end
                hi_next    = '0;
                step_next  = '0;
                state_next = S_MUL;
            end

            // shift-add multiply, LSB first; product ends in {hi, lo}
            S_MUL:
            begin
                alu_req.op_a = ALU_W'(hi_reg);
                alu_req.op_b = lo_reg[0] ? ALU_W'(sum_reg) : '0;
                hi_next      = alu_res[A_W:1];
                lo_next      = {alu_res[0], lo_reg[B_W-1:1]};
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    big_next   = 1'b0;
                    state_next = S_DIV;
                end
            end

            // restoring divide, one quotient bit a cycle
            S_DIV:
            begin
                alu_req.op_a = ALU_W'(rem_sh);
                alu_req.op_b = ALU_W'(divisor);
                alu_req.sub  = 1'b1;
                rem_next     = ge ? alu_res[D_W-1:0] : rem_sh[D_W-1:0];
                hi_next      = {hi_reg[A_W-2:0], lo_reg[B_W-1]};
                lo_next      = {lo_reg[B_W-2:0], 1'b0};
                q_next       = {q_reg[Q_W-2:0], ge};
                big_next     = big_reg | q_reg[Q_W-1];
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_RND;
                end
            end

            S_RND:
            begin
                alu_req.op_a = ALU_W'({rem_reg, 1'b0});
                alu_req.op_b = ALU_W'(divisor);
                alu_req.sub  = 1'b1;
                rnd_next     = ge;
                state_next   = S_INC;
            end

            S_INC:
            begin
                alu_req.op_a = ALU_W'(q_reg);
                alu_req.op_b = ALU_W'(rnd_reg);
                tmp_next     = alu_res;
                state_next   = S_OUT;
            end

            S_OUT:
            begin
                alu_req.op_b = tmp_reg;
                alu_req.sub  = neg_reg;
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    res.area   = sat ? (neg_reg ? ACC_MIN : ACC_MAX) : alu_res[AREA_W-1:0];
                    res.status = sat ? ST_SAT : ST_OK;
                    index_next = '0;
                    phase_next = '0;
                    first_next = '0;
                    sum_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            first_reg <= '0;
            sum_reg   <= '0;
            index_reg <= '0;
            phase_reg <= '0;
            mode_reg  <= '0;
            last_reg  <= '0;
            tmp_reg   <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            big_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            rnd_reg   <= 1'b0;
            dl_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            first_reg <= first_next;
            sum_reg   <= sum_next;
            index_reg <= index_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            last_reg  <= last_next;
            tmp_reg   <= tmp_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            big_reg   <= big_next;
            neg_reg   <= neg_next;
            rnd_reg   <= rnd_next;
            dl_reg    <= dl_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hdl/sni_checker.sv
`timescale 1ns / 1ps
// sni_checker: port-level assertions for the integrator, bound to the top level.
// Depends on sni_pkg and sampled_numerical_integrator.
module sni_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sni_pkg::AREA_W-1:0]       m_axis_tdata,
    input logic [sni_pkg::ST_W-1:0]         m_axis_tuser
);
    import sni_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a request always keeps the sequencer busy for the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready straight after a request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_COUNT) || (m_axis_tuser == ST_SAT))
        else $error("undefined status");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_COUNT) |-> (m_axis_tdata == '0))
        else $error("count error with non-zero area");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_SAT) |->
            (m_axis_tdata == ACC_MAX) || (m_axis_tdata == ACC_MIN))
        else $error("saturated area not at a bound");

endmodule

bind sampled_numerical_integrator sni_checker u_sni_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
